// ----- hw/rtl/tlvmp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// TLV/MMTP parser package
// Shared types and constants for the TLV/MMTP header parser.
// ---------------------------------------------------------------------------
package tlvmp_pkg;

  localparam logic [7:0] SYNC_BYTE         = 8'h7F;
  localparam logic [7:0] RST_CIP_TYPE      = 8'hFE;
  localparam logic [7:0] RST_PARTIAL_CODE  = 8'h20;
  localparam logic [7:0] RST_PARTIAL_SKIP  = 8'd24;
  localparam int         CFG_IDX_W         = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_CIP_TYPE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PARTIAL_CODE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PARTIAL_SKIP = 2'd2;
  localparam int         QUEUE_DEPTH       = 4;

  // One completed TLV record.
  typedef struct packed {
    logic [7:0]  tlv_type;
    logic [15:0] tlv_length;
    logic        mmtp_valid;
    logic [15:0] pkt_ident;
    logic [3:0]  pay_kind;
    logic        rap_bit;
    logic        has_mpu_seq;
    logic [31:0] mpu_seq;
    logic        first_fragment;
  } record_t;

endpackage
`default_nettype wire

// ----- hw/rtl/tlvmp_parser.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// TLV/MMTP byte parser
// Consumes one byte per cycle while byte_vld is high and produces one record at the end of each TLV.
// ---------------------------------------------------------------------------
module tlvmp_parser (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  byte_vld,
  input  wire  [7:0]           byte_in,
  input  wire  [7:0]           cip_type,
  input  wire  [7:0]           partial_code,
  input  wire  [7:0]           partial_skip,
  output logic                 rec_vld,
  output tlvmp_pkg::record_t   rec
);
  import tlvmp_pkg::*;

  typedef enum logic [3:0] {
    PH_HUNT, PH_TYPE, PH_LENH, PH_LENL, PH_CIP, PH_PSKIP, PH_MFIX, PH_CSKIP,
    PH_EXTH, PH_ESKIP, PH_MPUH, PH_MSEQ, PH_REST
  } phase_t;

  phase_t      ph_r, ph_nxt;
  phase_t      ph_step;
  logic [16:0] pos_r, pos_nxt;
  logic [7:0]  ttype_r, ttype_nxt;
  logic [15:0] tlen_r, tlen_nxt;
  logic [16:0] fofs_r, fofs_nxt;
  logic [16:0] erem_r, erem_nxt;
  logic [15:0] etyp_r, etyp_nxt;
  logic [7:0]  flags_r, flags_nxt;
  logic [3:0]  ptype_r, ptype_nxt;
  logic [15:0] pid_r, pid_nxt;
  logic [31:0] seq_r, seq_nxt;
  logic [1:0]  frag_r, frag_nxt;
  logic        fail_r, fail_nxt;
  logic        rec_vld_nxt;
  record_t     rec_nxt;
  logic [16:0] pos_inc, erem_dec, fofs_inc;
  logic        valid_c, mpu_c;

  always_comb begin
    ph_nxt = ph_r; pos_nxt = pos_r; ttype_nxt = ttype_r; tlen_nxt = tlen_r;
    fofs_nxt = fofs_r; erem_nxt = erem_r; etyp_nxt = etyp_r; flags_nxt = flags_r;
    ptype_nxt = ptype_r; pid_nxt = pid_r; seq_nxt = seq_r; frag_nxt = frag_r;
    fail_nxt = fail_r; rec_vld_nxt = 1'b0;
    ph_step = ph_r;
    pos_inc = pos_r + 17'd1;
    erem_dec = erem_r - 17'd1;
    fofs_inc = fofs_r + 17'd1;
    if (byte_vld) begin
      unique case (ph_r)
        PH_HUNT: if (byte_in == SYNC_BYTE) ph_nxt = PH_TYPE;
        PH_TYPE: begin ttype_nxt = byte_in; ph_nxt = PH_LENH; end
        PH_LENH: begin tlen_nxt = {byte_in, 8'h00}; ph_nxt = PH_LENL; end
        PH_LENL: begin
          tlen_nxt = {tlen_r[15:8], byte_in};
          pos_nxt = '0; fofs_nxt = '0; erem_nxt = '0; etyp_nxt = '0;
          flags_nxt = '0; ptype_nxt = '0; pid_nxt = '0; seq_nxt = '0; frag_nxt = '0;
          if ({tlen_r[15:8], byte_in} == 16'd0) begin
            fail_nxt = 1'b1; ph_nxt = PH_HUNT; rec_vld_nxt = 1'b1;
          end else if (ttype_r == cip_type) begin
            fail_nxt = 1'b0; ph_nxt = PH_CIP;
          end else begin
            fail_nxt = 1'b1; ph_nxt = PH_REST;
          end
        end
        default: begin
          case (ph_r)
            PH_CIP: if (pos_r == 17'd2) begin
              if (byte_in == partial_code && partial_skip != 8'd0) begin
                erem_nxt = {9'd0, partial_skip}; ph_nxt = PH_PSKIP;
              end else begin
                ph_nxt = PH_MFIX; fofs_nxt = '0;
              end
            end
            PH_PSKIP: begin
              erem_nxt = erem_dec;
              if (erem_dec == '0) begin ph_nxt = PH_MFIX; fofs_nxt = '0; end
            end
            PH_MFIX: begin
              if (fofs_r == 17'd0) flags_nxt = byte_in;
              else if (fofs_r == 17'd1) ptype_nxt = byte_in[3:0];
              else if (fofs_r == 17'd2) pid_nxt = {byte_in, 8'h00};
              else if (fofs_r == 17'd3) pid_nxt = {pid_r[15:8], byte_in};
              fofs_nxt = fofs_inc;
              if (fofs_inc >= 17'd8) begin
                if (flags_r[5]) begin
                  ph_nxt = PH_CSKIP; erem_nxt = 17'd4;
                end else if (ptype_r != 4'd0) ph_nxt = PH_REST;
                else if (flags_r[1]) begin ph_nxt = PH_EXTH; fofs_nxt = '0; end
                else begin ph_nxt = PH_MPUH; fofs_nxt = '0; end
              end
            end
            PH_CSKIP: begin
              erem_nxt = erem_dec;
              if (erem_dec == '0) begin
                if (ptype_r != 4'd0) ph_nxt = PH_REST;
                else if (flags_r[1]) begin ph_nxt = PH_EXTH; fofs_nxt = '0; end
                else begin ph_nxt = PH_MPUH; fofs_nxt = '0; end
              end
            end
            PH_EXTH: begin
              if (fofs_r == 17'd0) etyp_nxt = {byte_in, 8'h00};
              else if (fofs_r == 17'd1) etyp_nxt = {etyp_r[15:8], byte_in};
              else if (fofs_r == 17'd2) erem_nxt = {1'b0, byte_in, 8'h00};
              else erem_nxt = {erem_r[16:8], byte_in};
              fofs_nxt = fofs_inc;
              if (fofs_inc >= 17'd4) begin
                if (erem_nxt == '0) begin
                  ph_nxt = (etyp_nxt == 16'd0) ? PH_MPUH : PH_EXTH;
                  fofs_nxt = '0;
                end else ph_nxt = PH_ESKIP;
              end
            end
            PH_ESKIP: begin
              erem_nxt = erem_dec;
              if (erem_dec == '0) begin
                ph_nxt = (etyp_r == 16'd0) ? PH_MPUH : PH_EXTH;
                fofs_nxt = '0;
              end
            end
            PH_MPUH: begin
              if (fofs_r == 17'd2) frag_nxt = byte_in[2:1];
              fofs_nxt = fofs_inc;
              if (fofs_inc >= 17'd3) begin ph_nxt = PH_MSEQ; fofs_nxt = '0; end
            end
            PH_MSEQ: begin
              seq_nxt = {seq_r[23:0], byte_in};
              fofs_nxt = fofs_inc;
              if (fofs_inc >= 17'd4) ph_nxt = PH_REST;
            end
            default: ;
          endcase
          // Where parsing stands after this byte, before the end of the TLV
          // sends the phase back to hunting.
          ph_step = ph_nxt;
          pos_nxt = pos_inc;
          if (pos_inc >= {1'b0, tlen_r}) begin
            rec_vld_nxt = 1'b1; ph_nxt = PH_HUNT; pos_nxt = '0;
          end
        end
      endcase
    end
  end

  // The record takes the held fields after this byte's update, and it is
  // valid only when the parse had reached the tail of the payload.
  always_comb begin
    valid_c = (ph_step == PH_REST) && !fail_nxt;
    mpu_c   = valid_c && (ptype_nxt == 4'd0);
    rec_nxt.tlv_type       = ttype_nxt;
    rec_nxt.tlv_length     = tlen_nxt;
    rec_nxt.mmtp_valid     = valid_c;
    rec_nxt.pkt_ident      = valid_c ? pid_nxt : 16'd0;
    rec_nxt.pay_kind       = valid_c ? ptype_nxt : 4'd0;
    rec_nxt.rap_bit        = valid_c & flags_nxt[0];
    rec_nxt.has_mpu_seq    = mpu_c;
    rec_nxt.mpu_seq        = mpu_c ? seq_nxt : 32'd0;
    rec_nxt.first_fragment = mpu_c && (frag_nxt <= 2'd1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= PH_HUNT; pos_r <= '0; ttype_r <= '0; tlen_r <= '0; fofs_r <= '0;
      erem_r <= '0; etyp_r <= '0; flags_r <= '0; ptype_r <= '0; pid_r <= '0;
      seq_r <= '0; frag_r <= '0; fail_r <= 1'b0; rec_vld <= 1'b0;
    end else begin
      ph_r <= ph_nxt; pos_r <= pos_nxt; ttype_r <= ttype_nxt; tlen_r <= tlen_nxt;
      fofs_r <= fofs_nxt; erem_r <= erem_nxt; etyp_r <= etyp_nxt;
      flags_r <= flags_nxt; ptype_r <= ptype_nxt; pid_r <= pid_nxt;
      seq_r <= seq_nxt; frag_r <= frag_nxt; fail_r <= fail_nxt;
      rec_vld <= rec_vld_nxt;
    end
    rec <= rec_nxt;
  end

endmodule
`default_nettype wire

// ----- hw/rtl/tlvmp_rec_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// TLV/MMTP record queue
// Small register queue that holds finished records until they are taken.
// ---------------------------------------------------------------------------
module tlvmp_rec_fifo #(
  parameter int DEPTH = tlvmp_pkg::QUEUE_DEPTH
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 wr_en,
  input  tlvmp_pkg::record_t  wr_data,
  input  wire                 rd_en,
  output tlvmp_pkg::record_t  rd_data,
  output logic                empty,
  output logic                almost_full
);
  import tlvmp_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  record_t         mem_r [DEPTH];
  logic [AW-1:0]   wp_r, rp_r;
  logic [AW:0]     cnt_r, cnt_nxt;
  logic            do_wr, do_rd;

  assign do_rd = rd_en && (cnt_r != '0);
  assign do_wr = wr_en;
  assign empty = (cnt_r == '0);
  // Two slots are kept free: one for a record that is already in flight.
  assign almost_full = (cnt_r >= (AW+1)'(DEPTH - 2));
  assign rd_data = mem_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_wr && !do_rd) cnt_nxt = cnt_r + 1'b1;
    else if (!do_wr && do_rd) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_wr) wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      if (do_rd) rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (do_wr) mem_r[wp_r] <= wr_data;
  end

endmodule
`default_nettype wire

// ----- hw/rtl/tlv_mmtp_header_parser.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// TLV/MMTP header parser
// Byte-stream parser giving one header record per TLV packet.
// ---------------------------------------------------------------------------
// The block takes one byte per cycle and never stalls by itself: push is
// honored every cycle that full is low. A byte is parsed in the cycle it is
// taken; the record for a TLV is registered at the edge that transfers its
// last byte, is then written into the queue, and from there can be popped.
// Records wait in a queue of QUEUE_DEPTH entries, four by default; full rises
// when only two slots remain, since one record may still be in flight in the
// parser's output register. Configuration writes should be made while no TLV
// is in progress.
module tlv_mmtp_header_parser #(
  parameter int QUEUE_DEPTH = tlvmp_pkg::QUEUE_DEPTH
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               cfg_we,
  input  wire  [tlvmp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  [7:0]                        cfg_data,
  input  wire                               in_push,
  input  wire  [7:0]                        in_data_byte,
  output logic                              in_full,
  output logic                              out_empty,
  input  wire                               out_pop,
  output logic [7:0]                        out_tlv_type,
  output logic [15:0]                       out_tlv_length,
  output logic                              out_mmtp_valid,
  output logic [15:0]                       out_pkt_ident,
  output logic [3:0]                        out_pay_kind,
  output logic                              out_rap_bit,
  output logic                              out_has_mpu_seq,
  output logic [31:0]                       out_mpu_seq,
  output logic                              out_first_fragment
);
  import tlvmp_pkg::*;

  logic [7:0] cip_type_r, pcode_r, pskip_r;
  logic       rec_vld;
  record_t    rec, head;
  logic       afull;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cip_type_r <= RST_CIP_TYPE;
      pcode_r    <= RST_PARTIAL_CODE;
      pskip_r    <= RST_PARTIAL_SKIP;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CIP_TYPE:     cip_type_r <= cfg_data;
        CFG_PARTIAL_CODE: pcode_r    <= cfg_data;
        CFG_PARTIAL_SKIP: pskip_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_full = afull;

  tlvmp_parser u_parser (
    .clk(clk), .rst_n(rst_n), .byte_vld(in_push && !afull), .byte_in(in_data_byte),
    .cip_type(cip_type_r), .partial_code(pcode_r), .partial_skip(pskip_r),
    .rec_vld(rec_vld), .rec(rec)
  );

  tlvmp_rec_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk(clk), .rst_n(rst_n), .wr_en(rec_vld), .wr_data(rec),
    .rd_en(out_pop), .rd_data(head), .empty(out_empty), .almost_full(afull)
  );

  assign out_tlv_type       = head.tlv_type;
  assign out_tlv_length     = head.tlv_length;
  assign out_mmtp_valid     = head.mmtp_valid;
  assign out_pkt_ident      = head.pkt_ident;
  assign out_pay_kind       = head.pay_kind;
  assign out_rap_bit        = head.rap_bit;
  assign out_has_mpu_seq    = head.has_mpu_seq;
  assign out_mpu_seq        = head.mpu_seq;
  assign out_first_fragment = head.first_fragment;

endmodule
`default_nettype wire
